// File: rtl/kvmt_pkg.sv
package kvmt_pkg;

    // table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 5;

    // stream word widths, fields packed from bit 0, padded to whole bytes
    localparam int IN_BITS   = ACTION_W + KEY_W + VAL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = VAL_W + 1 + 1 + COUNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // request queue between front and back, depth a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // action codes as they arrive on the stream
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    // decoded operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_SEARCH
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    // result word, last member in the lowest bits
    typedef struct packed {
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
        logic               full_flag;
        logic               found;
        logic [VAL_W-1:0]   result_value;
    } t_rsp;

    // back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

// File: rtl/kvmt_front.sv
module kvmt_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action [1:0], key [33:2], value [65:34], zero padding above
    input  logic [kvmt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               o_req_valid,
    output kvmt_pkg::t_req                     o_req,
    input  logic                               i_req_pop
);

    kvmt_pkg::t_req                    r_q [kvmt_pkg::QDEPTH];
    logic [kvmt_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [kvmt_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [kvmt_pkg::QCNT_W-1:0]       r_cnt;
    kvmt_pkg::t_req                    w_dec;
    logic                              w_push;
    logic                              w_pop;
    logic [kvmt_pkg::ACTION_W-1:0]     w_action;

    // decode the incoming transaction, unused code acts as a search
    assign w_action = s_axis_tdata[kvmt_pkg::ACTION_W-1:0];
    always_comb begin
        w_dec.key   = s_axis_tdata[kvmt_pkg::ACTION_W +: kvmt_pkg::KEY_W];
        w_dec.value = s_axis_tdata[kvmt_pkg::ACTION_W + kvmt_pkg::KEY_W +: kvmt_pkg::VAL_W];
        case (w_action)
            kvmt_pkg::ACT_ADD:    w_dec.op = kvmt_pkg::OP_ADD;
            kvmt_pkg::ACT_REMOVE: w_dec.op = kvmt_pkg::OP_REMOVE;
            kvmt_pkg::ACT_SEARCH: w_dec.op = kvmt_pkg::OP_SEARCH;
            default:              w_dec.op = kvmt_pkg::OP_SEARCH;
        endcase
    end

    assign s_axis_tready = (r_cnt != kvmt_pkg::QCNT_W'(kvmt_pkg::QDEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_req_valid   = (r_cnt != '0);
    assign w_pop         = i_req_pop && o_req_valid;
    assign o_req         = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/kvmt_back.sv
module kvmt_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  kvmt_pkg::t_req                     i_req,
    output logic                               o_req_pop,
    input  logic                               i_cfg_valid,
    input  logic [kvmt_pkg::VAL_W-1:0]         i_cfg_data,
    output logic                               o_rsp_valid,
    output kvmt_pkg::t_rsp                     o_rsp,
    input  logic                               i_rsp_ready
);

    localparam logic [kvmt_pkg::IDX_W-1:0] LAST_IDX = kvmt_pkg::IDX_W'(kvmt_pkg::CAPACITY - 1);

    kvmt_pkg::t_state                  r_state;
    kvmt_pkg::t_state                  n_state;
    kvmt_pkg::t_req                    r_req;
    logic [kvmt_pkg::IDX_W-1:0]        r_scan_idx;
    logic                              r_cmp_vld;
    logic [kvmt_pkg::IDX_W-1:0]        r_cmp_idx;
    logic [kvmt_pkg::KEY_W-1:0]        r_key_rd;
    logic                              r_hit;
    logic [kvmt_pkg::IDX_W-1:0]        r_hit_idx;
    logic                              r_free;
    logic [kvmt_pkg::IDX_W-1:0]        r_free_idx;
    logic [kvmt_pkg::VAL_W-1:0]        r_val_rd;
    logic [kvmt_pkg::CAPACITY-1:0]     r_valid;
    logic [kvmt_pkg::CNT_W-1:0]        r_count;
    logic [kvmt_pkg::CNT_W-1:0]        w_count;
    logic [kvmt_pkg::VAL_W-1:0]        r_empty_val;
    logic                              r_out_vld;
    kvmt_pkg::t_rsp                    r_out;

    logic                              w_start;
    logic                              w_scan;
    logic                              w_commit;
    logic                              w_ins;
    logic                              w_upd;
    logic                              w_rem;
    logic                              w_full;
    logic [kvmt_pkg::IDX_W-1:0]        w_val_addr;

    logic [kvmt_pkg::KEY_W-1:0]        mem_key [kvmt_pkg::CAPACITY];
    logic [kvmt_pkg::VAL_W-1:0]        mem_val [kvmt_pkg::CAPACITY];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kvmt_pkg::ST_IDLE:  if (i_req_valid) n_state = kvmt_pkg::ST_SCAN;
            kvmt_pkg::ST_SCAN:  if (r_scan_idx == LAST_IDX) n_state = kvmt_pkg::ST_DRAIN;
            kvmt_pkg::ST_DRAIN: n_state = kvmt_pkg::ST_READ;
            kvmt_pkg::ST_READ:  n_state = kvmt_pkg::ST_DONE;
            kvmt_pkg::ST_DONE:  if (!r_out_vld || i_rsp_ready) n_state = kvmt_pkg::ST_IDLE;
            default:            n_state = kvmt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_start  = 1'b0;
        w_scan   = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            kvmt_pkg::ST_IDLE: w_start  = i_req_valid;
            kvmt_pkg::ST_SCAN: w_scan   = 1'b1;
            kvmt_pkg::ST_DONE: w_commit = !r_out_vld || i_rsp_ready;
            default: begin
            end
        endcase
    end

    assign o_req_pop = w_start;

    // decision from the scan result
    assign w_upd  = (r_req.op == kvmt_pkg::OP_ADD) && r_hit;
    assign w_ins  = (r_req.op == kvmt_pkg::OP_ADD) && !r_hit && r_free;
    assign w_full = (r_req.op == kvmt_pkg::OP_ADD) && !r_hit && !r_free;
    assign w_rem  = (r_req.op == kvmt_pkg::OP_REMOVE) && r_hit;
    assign w_val_addr = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        w_count = r_count;
        if (w_ins) begin
            w_count = r_count + 1'b1;
        end else if (w_rem) begin
            w_count = r_count - 1'b1;
        end
    end

    // key store, one read port walked by the scan
    always_ff @(posedge i_clk) begin
        if (w_commit && w_ins) begin
            mem_key[r_free_idx] <= r_req.key;
        end
        r_key_rd <= mem_key[r_scan_idx];
    end

    // value store, read at the matching slot
    always_ff @(posedge i_clk) begin
        if (w_commit && (w_ins || w_upd)) begin
            mem_val[w_val_addr] <= r_req.value;
        end
        r_val_rd <= mem_val[r_hit_idx];
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_req <= i_req;
        end
        r_cmp_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kvmt_pkg::ST_IDLE;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_free     <= 1'b0;
            r_free_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_scan;
            if (w_start) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
            end else if (w_scan) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            // one comparator per cycle: first matching slot, first free slot
            if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx] && (r_key_rd == r_req.key) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_valid[r_cmp_idx] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    // slot occupancy and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (w_commit) begin
            if (w_ins) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (w_rem) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            r_count <= w_count;
        end
    end

    // empty value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_val <= '0;
        end else if (i_cfg_valid) begin
            r_empty_val <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.result_value <= r_hit ? r_val_rd : r_empty_val;
            r_out.found        <= r_hit;
            r_out.full_flag    <= w_full;
            r_out.entry_count  <= kvmt_pkg::COUNT_W'(w_count);
            r_out.is_empty     <= (w_count == '0);
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

// File: rtl/key_value_map_table.sv
// Fixed-capacity key/value map with CAPACITY slots. Each input transaction
// adds (or overwrites), removes or looks up a 32-bit key and returns exactly
// one result: the old or found value (else the configured empty value), a
// found bit, a full flag for an add that found no free slot, and the entry
// count and empty flag after the action. Each item is taken from the request
// queue, then scanned one slot per cycle through the single key comparator
// on the key memory's read port; the read is drained, the stored value read,
// and the table written back as the output register loads, once it is free.
// A two-deep request queue in front and the output register behind let both
// streams stall independently. The empty value is to be written through the
// cfg port by the user while the block is idle, which is not enforced.
module key_value_map_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // action [1:0], key [33:2], value [65:34], zero padding above
    input  logic [kvmt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_value [31:0], found [32], full_flag [33], entry_count [38:34],
    // is_empty [39]
    output logic [kvmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kvmt_pkg::VAL_W-1:0]          i_cfg_data
);

    logic              w_req_valid;
    kvmt_pkg::t_req    w_req;
    logic              w_req_pop;
    kvmt_pkg::t_rsp    w_rsp;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    kvmt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_req_valid   (w_req_valid),
        .o_req         (w_req),
        .i_req_pop     (w_req_pop)
    );

    kvmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (m_axis_tvalid),
        .o_rsp       (w_rsp),
        .i_rsp_ready (m_axis_tready)
    );

    // pack the result, zero padding above the fields
    assign m_axis_tdata = kvmt_pkg::OUT_DATA_W'(w_rsp);

endmodule

// File: rtl/kvmt_checker.sv
module kvmt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [kvmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    kvmt_pkg::t_rsp w_rsp;

    assign w_rsp = m_axis_tdata[kvmt_pkg::OUT_BITS-1:0];

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_rsp.is_empty == (w_rsp.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // a failed add means a full table and an absent key
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_rsp.full_flag |->
            !w_rsp.found && (w_rsp.entry_count == kvmt_pkg::COUNT_W'(kvmt_pkg::CAPACITY)))
        else $error("full flag without a full table");

    // the count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (w_rsp.entry_count <= kvmt_pkg::COUNT_W'(kvmt_pkg::CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind key_value_map_table kvmt_checker u_checker (.*);
